// ===== rtl/wsfd_pkg.sv =====
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_BYTE0   = 3'd0,
    PH_BYTE1   = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY_S   = 3'd4,
    PH_KEY_16  = 3'd5,
    PH_KEY_64  = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_t;

  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // Header byte counts at which each header part is complete.
  localparam logic [3:0] HDR_EXT16_DONE = 4'd4;
  localparam logic [3:0] HDR_EXT64_DONE = 4'd10;
  localparam logic [3:0] HDR_KEY_S_DONE  = 4'd6;
  localparam logic [3:0] HDR_KEY_16_DONE = 4'd8;
  localparam logic [3:0] HDR_KEY_64_DONE = 4'd14;
  localparam logic [3:0] HDR_BASE        = 4'd2;

  localparam logic REC_HEADER  = 1'b0;
  localparam logic REC_PAYLOAD = 1'b1;

endpackage

// ===== rtl/websocket_frame_deframer_top.sv =====
// WebSocket (RFC 6455) frame deframer. Feed the stream one byte per input
// transaction, starting at a frame border. Header bytes produce no result;
// when the header is complete one header record (record_type 0) comes out,
// marked end_of_frame when the payload length is zero. Each payload byte then
// comes out unmasked (record_type 1) with the header fields repeated, the last
// one marked end_of_frame, after which the parser expects the next frame.
// Unmasked frames pass payload unchanged; a 64-bit length with bit 63 set is
// flagged in length_too_large and still parsed. Each byte is parsed by the
// state update between the input and the result register, and a byte is
// accepted in every cycle while the result register is empty or being taken,
// so the block sustains one byte per clock.
module websocket_frame_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_record_type,
  output logic        out_final_fragment,
  output logic [2:0]  out_reserved_bits,
  output logic [3:0]  out_frame_opcode,
  output logic        out_is_masked,
  output logic [63:0] out_payload_length,
  output logic [3:0]  out_header_bytes,
  output logic        out_length_too_large,
  output logic [7:0]  out_payload_byte,
  output logic        out_end_of_frame
);
  import wsfd_pkg::*;

  // Parser state
  phase_t       phase_r, phase_nxt;
  logic [3:0]   hbc_r, hbc_nxt;
  logic [7:0]   fhb_r, fhb_nxt;
  logic         mask_r, mask_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [31:0]  key_r, key_nxt;
  logic [63:0]  off_r, off_nxt;

  // Result register
  logic         out_valid_r;
  logic         rec_type_r;
  logic [7:0]   fhb_out_r;
  logic         mask_out_r;
  logic [63:0]  len_out_r;
  logic [3:0]   hbc_out_r;
  logic [7:0]   pbyte_r;
  logic         eof_r;

  logic         fire_in;
  logic [3:0]   hbc_inc;
  logic [63:0]  off_inc;
  logic         last_payload;
  logic         hdr_done;
  logic         emit;
  logic         eof;
  logic [7:0]   key_byte;

  // Accept while the result register is empty or is being drained.
  assign in_stall = out_valid_r && out_stall;
  assign fire_in  = in_valid && !in_stall;

  assign hbc_inc      = hbc_r + 4'd1;
  assign off_inc      = off_r + 64'd1;
  assign last_payload = (off_inc == len_r);

  always_comb begin
    case (off_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Datapath: field updates and header completion
  always_comb begin
    fhb_nxt  = fhb_r;
    hbc_nxt  = hbc_r;
    mask_nxt = mask_r;
    len_nxt  = len_r;
    key_nxt  = key_r;
    off_nxt  = off_r;
    hdr_done = 1'b0;
    unique case (phase_r) inside
      PH_BYTE0: begin
        fhb_nxt  = in_stream_byte;
        hbc_nxt  = 4'd1;
        mask_nxt = 1'b0;
        len_nxt  = '0;
        key_nxt  = '0;
        off_nxt  = '0;
      end
      PH_BYTE1: begin
        hbc_nxt  = HDR_BASE;
        mask_nxt = in_stream_byte[7];
        if (in_stream_byte[6:0] < LEN_EXT16) begin
          len_nxt  = {57'd0, in_stream_byte[6:0]};
          hdr_done = !in_stream_byte[7];
        end
      end
      PH_EXT16, PH_EXT64: begin
        len_nxt = {len_r[55:0], in_stream_byte};
        hbc_nxt = hbc_inc;
        if (phase_r == PH_EXT16) begin
          hdr_done = (hbc_inc == HDR_EXT16_DONE) && !mask_r;
        end else begin
          hdr_done = (hbc_inc == HDR_EXT64_DONE) && !mask_r;
        end
      end
      PH_KEY_S, PH_KEY_16, PH_KEY_64: begin
        key_nxt = {key_r[23:0], in_stream_byte};
        hbc_nxt = hbc_inc;
        if (phase_r == PH_KEY_S) begin
          hdr_done = (hbc_inc == HDR_KEY_S_DONE);
        end else if (phase_r == PH_KEY_16) begin
          hdr_done = (hbc_inc == HDR_KEY_16_DONE);
        end else begin
          hdr_done = (hbc_inc == HDR_KEY_64_DONE);
        end
      end
      default: begin
        off_nxt = off_inc;
      end
    endcase
    // A completed header restarts the payload offset.
    if (hdr_done) begin
      off_nxt = '0;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r) inside
      PH_BYTE0: phase_nxt = PH_BYTE1;
      PH_BYTE1: begin
        if (in_stream_byte[6:0] == LEN_EXT16) begin
          phase_nxt = PH_EXT16;
        end else if (in_stream_byte[6:0] > LEN_EXT16) begin
          phase_nxt = PH_EXT64;
        end else if (in_stream_byte[7]) begin
          phase_nxt = PH_KEY_S;
        end
      end
      PH_EXT16: begin
        if (hbc_inc == HDR_EXT16_DONE && mask_r) phase_nxt = PH_KEY_16;
      end
      PH_EXT64: begin
        if (hbc_inc == HDR_EXT64_DONE && mask_r) phase_nxt = PH_KEY_64;
      end
      PH_KEY_S, PH_KEY_16, PH_KEY_64: ;
      default: begin
        if (last_payload) phase_nxt = PH_BYTE0;
      end
    endcase
    // Header complete: drop to the frame border on empty payload.
    if (hdr_done) begin
      phase_nxt = (len_nxt == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
    end
  end

  // Result decode
  always_comb begin
    emit = hdr_done || (phase_r == PH_PAYLOAD);
    eof  = hdr_done ? (len_nxt == 64'd0) : last_payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BYTE0;
      hbc_r       <= '0;
      fhb_r       <= '0;
      mask_r      <= 1'b0;
      len_r       <= '0;
      key_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire_in) begin
        phase_r <= phase_nxt;
        hbc_r   <= hbc_nxt;
        fhb_r   <= fhb_nxt;
        mask_r  <= mask_nxt;
        len_r   <= len_nxt;
        key_r   <= key_nxt;
        off_r   <= off_nxt;
      end
      // Load a new result, or clear once the old one is taken.
      if (fire_in && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: no reset needed, guarded by out_valid_r.
  always_ff @(posedge clk) begin
    if (fire_in && emit) begin
      rec_type_r <= hdr_done ? REC_HEADER : REC_PAYLOAD;
      fhb_out_r  <= fhb_nxt;
      mask_out_r <= mask_nxt;
      len_out_r  <= len_nxt;
      hbc_out_r  <= hbc_nxt;
      pbyte_r    <= hdr_done ? 8'd0 : (in_stream_byte ^ key_byte);
      eof_r      <= eof;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_record_type      = rec_type_r;
  assign out_final_fragment   = fhb_out_r[7];
  assign out_reserved_bits    = fhb_out_r[6:4];
  assign out_frame_opcode     = fhb_out_r[3:0];
  assign out_is_masked        = mask_out_r;
  assign out_payload_length   = len_out_r;
  assign out_header_bytes     = hbc_out_r;
  assign out_length_too_large = len_out_r[63];
  assign out_payload_byte     = pbyte_r;
  assign out_end_of_frame     = eof_r;

endmodule

// ===== rtl/wsfd_checker.sv =====
module wsfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_type,
  input logic        out_final_fragment,
  input logic [2:0]  out_reserved_bits,
  input logic [3:0]  out_frame_opcode,
  input logic        out_is_masked,
  input logic [63:0] out_payload_length,
  input logic [3:0]  out_header_bytes,
  input logic        out_length_too_large,
  input logic [7:0]  out_payload_byte,
  input logic        out_end_of_frame
);

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_length) && $stable(out_record_type)
      && $stable(out_end_of_frame) && $stable(out_final_fragment)
      && $stable(out_reserved_bits) && $stable(out_frame_opcode)
      && $stable(out_is_masked) && $stable(out_header_bytes))
    else $error("stalled result changed");

  a_hdr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_type |-> out_header_bytes == 4'd2
      || out_header_bytes == 4'd4 || out_header_bytes == 4'd6
      || out_header_bytes == 4'd8 || out_header_bytes == 4'd10
      || out_header_bytes == 4'd14)
    else $error("impossible header length");

  a_empty_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_type && out_payload_length == 64'd0
      |-> out_end_of_frame)
    else $error("empty frame header not marked last");

  a_too_large: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length_too_large == out_payload_length[63])
    else $error("length flag disagrees with length");

  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_record_type |-> out_payload_byte == 8'd0)
    else $error("header record carries payload byte");

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (.*);

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsfd_pkg::*;

  // Run shape: total stream bytes, receiver squeeze length, watchdog limit.
  localparam int STREAM_BYTES   = 1500;
  localparam int SQUEEZE_AFTER  = 300;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int IDLE_LIMIT     = 4000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_REPORTS    = 10;

  // 7-bit length code that announces a 64-bit extended length.
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef enum logic [3:0] {
    OP_CONT   = 4'h0,
    OP_TEXT   = 4'h1,
    OP_BINARY = 4'h2,
    OP_CLOSE  = 4'h8,
    OP_PING   = 4'h9,
    OP_PONG   = 4'hA,
    OP_RSVD_F = 4'hF
  } ws_opcode_t;

  typedef enum int {LEN_SHORT, LEN_16, LEN_64} len_code_t;

  // One result transaction, in port order.
  typedef struct packed {
    logic        rtype;
    logic        fin;
    logic [2:0]  rsv;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] len;
    logic [3:0]  hdr_len;
    logic        too_large;
    logic [7:0]  data;
    logic        eof;
  } deframe_rec_t;

  typedef struct {
    logic [7:0]   b;
    bit           known;
    deframe_rec_t rec;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_record_type;
  logic        out_final_fragment;
  logic [2:0]  out_reserved_bits;
  logic [3:0]  out_frame_opcode;
  logic        out_is_masked;
  logic [63:0] out_payload_length;
  logic [3:0]  out_header_bytes;
  logic        out_length_too_large;
  logic [7:0]  out_payload_byte;
  logic        out_end_of_frame;

  // Typed-in expectation that travels with the byte on the input channel.
  bit           tab_known = 1'b0;
  deframe_rec_t tab_rec = '0;

  // Predictor copy of the parser state, at its reset values.
  phase_t      fr_phase   = PH_BYTE0;
  logic [3:0]  fr_hdr_cnt = '0;
  logic [7:0]  fr_byte0   = '0;
  logic        fr_masked  = 1'b0;
  logic [63:0] fr_len     = '0;
  logic [31:0] fr_key     = '0;
  logic [63:0] fr_off     = '0;

  deframe_rec_t frame_q[$];   // expected results, oldest first
  stim_row_t    dir_rows[$];  // directed stimulus
  int n_sent       = 0;
  int n_in         = 0;
  int n_mismatch   = 0;
  int idle_cycles  = 0;
  bit squeeze_done = 1'b0;

  always #1 clk = ~clk;

  websocket_frame_deframer_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_stream_byte      (in_stream_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_type     (out_record_type),
    .out_final_fragment  (out_final_fragment),
    .out_reserved_bits   (out_reserved_bits),
    .out_frame_opcode    (out_frame_opcode),
    .out_is_masked       (out_is_masked),
    .out_payload_length  (out_payload_length),
    .out_header_bytes    (out_header_bytes),
    .out_length_too_large(out_length_too_large),
    .out_payload_byte    (out_payload_byte),
    .out_end_of_frame    (out_end_of_frame)
  );

  // ---------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------

  // Header fields of the current frame; every result repeats them.
  function automatic deframe_rec_t frame_fields();
    deframe_rec_t r;
    r = '0;
    r.fin       = fr_byte0[7];
    r.rsv       = fr_byte0[6:4];
    r.opcode    = fr_byte0[3:0];
    r.masked    = fr_masked;
    r.len       = fr_len;
    r.hdr_len   = fr_hdr_cnt;
    r.too_large = fr_len[63];
    return r;
  endfunction

  // Header complete: emit the header record, then enter the payload or,
  // for an empty payload, drop straight back to the frame border.
  task automatic header_emit(output bit emit, output deframe_rec_t rec);
    rec       = frame_fields();
    rec.rtype = REC_HEADER;
    if (fr_len == 64'd0) begin
      rec.eof  = 1'b1;
      fr_phase = PH_BYTE0;
    end else begin
      rec.eof  = 1'b0;
      fr_off   = '0;
      fr_phase = PH_PAYLOAD;
    end
    emit = 1'b1;
  endtask

  // Length decoded: collect the key if there is one, else close the header.
  task automatic length_known(input phase_t key_phase, output bit emit,
                              output deframe_rec_t rec);
    if (fr_masked) begin
      fr_phase = key_phase;
      emit     = 1'b0;
      rec      = '0;
    end else begin
      header_emit(emit, rec);
    end
  endtask

  task automatic deframe_step(input logic [7:0] b, output bit emit,
                              output deframe_rec_t rec);
    logic [6:0] len7;
    logic [3:0] key_end;
    logic [7:0] key_byte;
    emit = 1'b0;
    rec  = '0;
    case (fr_phase)
      PH_BYTE0: begin
        fr_byte0   = b;
        fr_hdr_cnt = 4'd1;
        fr_masked  = 1'b0;
        fr_len     = '0;
        fr_key     = '0;
        fr_off     = '0;
        fr_phase   = PH_BYTE1;
      end
      PH_BYTE1: begin
        fr_hdr_cnt = HDR_BASE;
        fr_masked  = b[7];
        len7       = b[6:0];
        if (len7 < LEN_EXT16) begin
          fr_len = {57'd0, len7};
          length_known(PH_KEY_S, emit, rec);
        end else begin
          fr_phase = (len7 == LEN_EXT16) ? PH_EXT16 : PH_EXT64;
        end
      end
      PH_EXT16, PH_EXT64: begin
        fr_len     = {fr_len[55:0], b};
        fr_hdr_cnt = fr_hdr_cnt + 4'd1;
        if (fr_phase == PH_EXT16) begin
          if (fr_hdr_cnt == HDR_EXT16_DONE) length_known(PH_KEY_16, emit, rec);
        end else if (fr_hdr_cnt == HDR_EXT64_DONE) begin
          length_known(PH_KEY_64, emit, rec);
        end
      end
      PH_KEY_S, PH_KEY_16, PH_KEY_64: begin
        fr_key     = {fr_key[23:0], b};
        fr_hdr_cnt = fr_hdr_cnt + 4'd1;
        key_end    = (fr_phase == PH_KEY_S)  ? HDR_KEY_S_DONE :
                     (fr_phase == PH_KEY_16) ? HDR_KEY_16_DONE : HDR_KEY_64_DONE;
        if (fr_hdr_cnt == key_end) header_emit(emit, rec);
      end
      default: begin
        // Key byte at offset mod 4, first key byte in the top bits.
        key_byte  = fr_key[8 * (3 - fr_off[1:0]) +: 8];
        rec       = frame_fields();
        rec.rtype = REC_PAYLOAD;
        rec.data  = b ^ key_byte;
        fr_off    = fr_off + 64'd1;
        if (fr_off == fr_len) begin
          rec.eof  = 1'b1;
          fr_phase = PH_BYTE0;
        end
        emit = 1'b1;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic string fmt_rec(input deframe_rec_t r);
    return $sformatf({"type=%0d fin=%0d rsv=%0d op=%0d mask=%0d len=%h hdr=%0d",
                      " big=%0d data=%h eof=%0d"},
                     r.rtype, r.fin, r.rsv, r.opcode, r.masked, r.len, r.hdr_len,
                     r.too_large, r.data, r.eof);
  endfunction

  task automatic check_result(input deframe_rec_t got);
    deframe_rec_t want;
    string bad;
    bad = "";
    if (frame_q.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS) $display("unexpected result: %s", fmt_rec(got));
      return;
    end
    want = frame_q[0];
    frame_q.delete(0);
    if (got.rtype     !== want.rtype)     bad = {bad, " record_type"};
    if (got.fin       !== want.fin)       bad = {bad, " final_fragment"};
    if (got.rsv       !== want.rsv)       bad = {bad, " reserved_bits"};
    if (got.opcode    !== want.opcode)    bad = {bad, " frame_opcode"};
    if (got.masked    !== want.masked)    bad = {bad, " is_masked"};
    if (got.len       !== want.len)       bad = {bad, " payload_length"};
    if (got.hdr_len   !== want.hdr_len)   bad = {bad, " header_bytes"};
    if (got.too_large !== want.too_large) bad = {bad, " length_too_large"};
    if (got.data      !== want.data)      bad = {bad, " payload_byte"};
    if (got.eof       !== want.eof)       bad = {bad, " end_of_frame"};
    if (bad != "") begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS) begin
        $display("result mismatch in%s", bad);
        $display("  expected %s", fmt_rec(want));
        $display("  actual   %s", fmt_rec(got));
      end
    end
  endtask

  // Sample both channels at the edge. Check the result side first: a byte
  // taken at this edge cannot produce the result leaving at this edge.
  always @(posedge clk) begin : monitor
    bit           emit;
    deframe_rec_t rec;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        check_result({out_record_type, out_final_fragment, out_reserved_bits,
                      out_frame_opcode, out_is_masked, out_payload_length,
                      out_header_bytes, out_length_too_large, out_payload_byte,
                      out_end_of_frame});
      end
      if (in_valid && !in_stall) begin
        deframe_step(in_stream_byte, emit, rec);
        if (emit) begin
          // Directed rows override the predicted record with a typed one.
          if (tab_known) rec = tab_rec;
          frame_q.push_back(rec);
        end
        n_in++;
      end
      // Watchdog: count cycles in which neither channel moves a transaction.
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
          $display("FAIL websocket_frame_deframer_top");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  // Idle length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic deframe_rec_t mk_rec(input logic rtype, input logic fin,
                                          input logic [2:0] rsv, input logic [3:0] op,
                                          input logic masked, input logic [63:0] len,
                                          input logic [3:0] hdr_len,
                                          input logic [7:0] data, input logic eof);
    return {rtype, fin, rsv, op, masked, len, hdr_len, len[63], data, eof};
  endfunction

  task automatic add_row(input logic [7:0] b, input bit known, input deframe_rec_t rec);
    stim_row_t row;
    row.b     = b;
    row.known = known;
    row.rec   = rec;
    dir_rows.push_back(row);
  endtask

  // Offer one byte and hold it until the block takes it. Lower valid only
  // when a gap follows, so valid never drops and rises in one step.
  task automatic send_byte(input logic [7:0] b, input bit known,
                           input deframe_rec_t rec, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    tab_known      <= known;
    tab_rec        <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Assemble one frame byte by byte and send it. n_payload may fall short
  // of the announced length for a frame that never ends.
  task automatic send_frame(input logic [7:0] b0, input logic masked,
                            input len_code_t kind, input logic [63:0] plen,
                            input int n_payload, input bit calm);
    logic [7:0]  fb[$];
    logic [31:0] key;
    fb.push_back(b0);
    case (kind)
      LEN_SHORT: fb.push_back({masked, plen[6:0]});
      LEN_16: begin
        fb.push_back({masked, LEN_EXT16});
        fb.push_back(plen[15:8]);
        fb.push_back(plen[7:0]);
      end
      default: begin
        fb.push_back({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) fb.push_back(plen[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      key = $urandom;
      for (int i = 3; i >= 0; i--) fb.push_back(key[8 * i +: 8]);
    end
    for (int i = 0; i < n_payload; i++) fb.push_back(8'($urandom_range(0, 255)));
    foreach (fb[i]) send_byte(fb[i], 1'b0, '0, calm);
  endtask

  // Receiver: random stalls with calm runs between them, and once a long
  // squeeze while the sender keeps offering, so the block backs up.
  initial begin : receiver
    int hold;
    int run;
    wait (rst_n);
    forever begin
      if (!squeeze_done && n_in >= SQUEEZE_AFTER) begin
        squeeze_done = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    len_code_t   kind;
    logic [63:0] plen;
    int          r;

    // Unmasked empty frame with a non-minimal 16-bit length of zero.
    add_row({1'b0, 3'b111, OP_PONG}, 1'b0, '0);
    add_row({1'b0, LEN_EXT16}, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b1, mk_rec(REC_HEADER, 1'b0, 3'b111, OP_PONG, 1'b0, 64'd0,
                                HDR_EXT16_DONE, 8'h00, 1'b1));
    // Unmasked one-byte text frame: the byte passes unchanged.
    add_row({1'b1, 3'b000, OP_TEXT}, 1'b0, '0);
    add_row(8'h01, 1'b1, mk_rec(REC_HEADER, 1'b1, 3'b000, OP_TEXT, 1'b0, 64'd1,
                                HDR_BASE, 8'h00, 1'b0));
    add_row(8'hFF, 1'b1, mk_rec(REC_PAYLOAD, 1'b1, 3'b000, OP_TEXT, 1'b0, 64'd1,
                                HDR_BASE, 8'hFF, 1'b1));
    // Masked two-byte ping, key DE AD BE EF: payload unmasks to 00 FF.
    add_row({1'b0, 3'b000, OP_PING}, 1'b0, '0);
    add_row(8'h82, 1'b0, '0);
    add_row(8'hDE, 1'b0, '0);
    add_row(8'hAD, 1'b0, '0);
    add_row(8'hBE, 1'b0, '0);
    add_row(8'hEF, 1'b1, mk_rec(REC_HEADER, 1'b0, 3'b000, OP_PING, 1'b1, 64'd2,
                                HDR_KEY_S_DONE, 8'h00, 1'b0));
    add_row(8'hDE, 1'b1, mk_rec(REC_PAYLOAD, 1'b0, 3'b000, OP_PING, 1'b1, 64'd2,
                                HDR_KEY_S_DONE, 8'h00, 1'b0));
    add_row(8'h52, 1'b1, mk_rec(REC_PAYLOAD, 1'b0, 3'b000, OP_PING, 1'b1, 64'd2,
                                HDR_KEY_S_DONE, 8'hFF, 1'b1));
    // Unmasked empty binary frame with a 64-bit length of zero.
    add_row({1'b0, 3'b000, OP_BINARY}, 1'b0, '0);
    add_row({1'b0, LEN_EXT64}, 1'b0, '0);
    repeat (7) add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b1, mk_rec(REC_HEADER, 1'b0, 3'b000, OP_BINARY, 1'b0, 64'd0,
                                HDR_EXT64_DONE, 8'h00, 1'b1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].known, dir_rows[i].rec, 1'b0);

    // Random well-formed frames: random header bits, opcode and key, mostly
    // short payloads so that many frames fit; some frames go without gaps.
    while (n_sent < STREAM_BYTES) begin
      r    = $urandom_range(0, 9);
      kind = (r < 6) ? LEN_SHORT : (r < 8) ? LEN_16 : LEN_64;
      r    = $urandom_range(0, 99);
      if (r < 70)      plen = 64'($urandom_range(0, 8));
      else if (r < 95) plen = 64'($urandom_range(9, 40));
      else             plen = 64'($urandom_range(41, (kind == LEN_SHORT) ? 125 : 300));
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), kind, plen,
                 int'(plen), $urandom_range(0, 7) == 0);
    end

    // Last frame: every header bit set, largest length, so bit 63 is flagged.
    // It can never complete; feed a few payload bytes and stop there.
    send_frame({1'b1, 3'b111, OP_RSVD_F}, 1'b1, LEN_64, 64'hFFFF_FFFF_FFFF_FFFF,
               16, 1'b0);
    in_valid <= 1'b0;

    // Drain, then let the block settle to show any stray result.
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_q.size() != 0) n_mismatch += frame_q.size();

    if (n_mismatch == 0) begin
      $display("PASS websocket_frame_deframer_top");
    end else begin
      $display("FAIL websocket_frame_deframer_top");
    end
    $finish;
  end

endmodule
